// ----- rtl/core/avc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the agent velocity clamp step core.
// Used by every module; depends on nothing.
package avc_pkg;

    // Vector and limit widths.
    localparam int VEC_W = 32;
    localparam int LIM_W = 31;
    localparam int MAG_W = VEC_W;

    // Square root of a squared length.
    localparam int SQ_W       = 2 * MAG_W;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int SQRT_REM_W = ROOT_W + 2;

    // Division of magnitude times limit by the root.
    localparam int PROD_W    = MAG_W + LIM_W;
    localparam int QUO_W     = LIM_W;
    localparam int DIV_STEPS = QUO_W;

    // Configuration registers: two per group, accel limit first.
    localparam int N_GROUPS   = 4;
    localparam int GROUP_W    = 2;
    localparam int N_REGS     = 2 * N_GROUPS;
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIM_W;
    localparam logic CFG_KIND_ACCEL = 1'b0;
    localparam logic CFG_KIND_SPEED = 1'b1;

    // Register stages through one clamp unit.
    localparam int CLAMP_LAT = 3 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic [LIM_W-1:0]        lim_t;
    typedef logic [MAG_W-1:0]        mag_t;

    typedef struct packed {
        vec_t               pos_x;
        vec_t               pos_y;
        vec_t               vel_x;
        vec_t               vel_y;
        vec_t               acc_x;
        vec_t               acc_y;
        logic [GROUP_W-1:0] group_index;
    } in_item_t;

    typedef struct packed {
        vec_t new_pos_x;
        vec_t new_pos_y;
        vec_t new_vel_x;
        vec_t new_vel_y;
    } out_item_t;

    // State handed from one square root cell to the next.
    typedef struct packed {
        logic [SQ_W-1:0]       rad;
        logic [SQRT_REM_W-1:0] rem;
        logic [ROOT_W-1:0]     root;
    } sqrt_state_t;

    // One lane of the restoring divider.
    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [QUO_W-1:0]  num;
        logic [QUO_W-1:0]  quo;
    } div_lane_t;

    typedef struct packed {
        div_lane_t         lane_x;
        div_lane_t         lane_y;
        logic [ROOT_W-1:0] dvs;
    } div_state_t;

    // Signed add that saturates to the vector range.
    function automatic vec_t sat_add(vec_t a, vec_t b);
        logic signed [VEC_W:0] sum;
        vec_t                  res;
        sum = {a[VEC_W-1], a} + {b[VEC_W-1], b};
        if (sum[VEC_W] != sum[VEC_W-1]) begin
            res = sum[VEC_W] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}};
        end
        else begin
            res = sum[VEC_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/avc_stream_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one request payload.
// The payload type comes in as a parameter; uses nothing else.
interface avc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/avc_sqrt_cell.sv -----
`timescale 1ns / 1ps
// One step of the digit-by-digit integer square root: two radicand bits
// in, one root bit out, registered. Depends on avc_pkg.
module avc_sqrt_cell (
    input  logic                 clk,
    input  logic                 en,
    input  avc_pkg::sqrt_state_t st_in,
    output avc_pkg::sqrt_state_t st_out
);
    import avc_pkg::*;

    localparam int SH_W = SQRT_REM_W + 2;

    logic [SH_W-1:0] rem_sh;
    logic [SH_W-1:0] trial;
    logic            take;
    sqrt_state_t     st_next;
    sqrt_state_t     st_reg;

    // Bring down the next two radicand bits and try the root bit.
    assign rem_sh = {st_in.rem, st_in.rad[SQ_W-1 -: 2]};
    assign trial  = SH_W'({st_in.root, 2'b01});
    assign take   = (rem_sh >= trial);

    always_comb
    begin
        st_next.rad  = {st_in.rad[SQ_W-3:0], 2'b00};
        st_next.rem  = take ? SQRT_REM_W'(rem_sh - trial) : SQRT_REM_W'(rem_sh);
        st_next.root = {st_in.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;
endmodule

// ----- rtl/core/avc_div_cell.sv -----
`timescale 1ns / 1ps
// One quotient bit of the restoring divider for both vector components,
// registered. Depends on avc_pkg.
module avc_div_cell (
    input  logic                clk,
    input  logic                en,
    input  avc_pkg::div_state_t st_in,
    output avc_pkg::div_state_t st_out
);
    import avc_pkg::*;

    div_state_t st_next;
    div_state_t st_reg;

    // Shift in one numerator bit and subtract the divisor if it fits.
    function automatic div_lane_t lane_step(div_lane_t l, logic [ROOT_W-1:0] d);
        logic [ROOT_W:0] sh;
        logic            tk;
        div_lane_t       r;
        sh    = {l.rem, l.num[QUO_W-1]};
        tk    = (sh >= {1'b0, d});
        r.rem = tk ? ROOT_W'(sh - {1'b0, d}) : sh[ROOT_W-1:0];
        r.num = {l.num[QUO_W-2:0], 1'b0};
        r.quo = {l.quo[QUO_W-2:0], tk};
        return r;
    endfunction

    always_comb
    begin
        st_next.lane_x = lane_step(st_in.lane_x, st_in.dvs);
        st_next.lane_y = lane_step(st_in.lane_y, st_in.dvs);
        st_next.dvs    = st_in.dvs;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;
endmodule

// ----- rtl/core/avc_clamp.sv -----
`timescale 1ns / 1ps
// Clamps a 2D vector to a length limit: squares, compare, a chain of square
// root cells, a scale multiply and a chain of divider cells. Carries a
// sideband alongside. Depends on avc_pkg, avc_sqrt_cell and avc_div_cell.
module avc_clamp #(
    parameter int SIDE_W = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  avc_pkg::vec_t       in_x,
    input  avc_pkg::vec_t       in_y,
    input  avc_pkg::lim_t       in_lim,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_vld,
    output avc_pkg::vec_t       out_x,
    output avc_pkg::vec_t       out_y,
    output logic [SIDE_W-1:0]   out_side
);
    import avc_pkg::*;

    typedef struct packed {
        logic              sx;
        logic              sy;
        mag_t              ax;
        mag_t              ay;
        lim_t              lim;
        logic              over;
        logic [SIDE_W-1:0] side;
    } meta_t;

    function automatic mag_t mag_of(vec_t v);
        return v[VEC_W-1] ? mag_t'(~v + 1'b1) : mag_t'(v);
    endfunction

    function automatic vec_t apply_sign(logic s, mag_t m);
        return s ? vec_t'(~m + 1'b1) : vec_t'(m);
    endfunction

    // Front stages: magnitudes, squares, squared length against limit.
    logic            s0_vld_reg, s1_vld_reg, s2_vld_reg;
    meta_t           s0_meta_reg, s1_meta_reg, s2_meta_reg;
    meta_t           s0_meta_next, s2_meta_next;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, ll_reg;
    logic [SQ_W-1:0] sum_reg;

    always_comb
    begin
        s0_meta_next.sx   = in_x[VEC_W-1];
        s0_meta_next.sy   = in_y[VEC_W-1];
        s0_meta_next.ax   = mag_of(in_x);
        s0_meta_next.ay   = mag_of(in_y);
        s0_meta_next.lim  = in_lim;
        s0_meta_next.over = 1'b0;
        s0_meta_next.side = in_side;
    end

    always_comb
    begin
        s2_meta_next      = s1_meta_reg;
        s2_meta_next.over = ((sqx_reg + sqy_reg) > ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_meta_reg <= s0_meta_next;
            s1_meta_reg <= s0_meta_reg;
            sqx_reg     <= s0_meta_reg.ax * s0_meta_reg.ax;
            sqy_reg     <= s0_meta_reg.ay * s0_meta_reg.ay;
            ll_reg      <= s0_meta_reg.lim * s0_meta_reg.lim;
            s2_meta_reg <= s2_meta_next;
            sum_reg     <= sqx_reg + sqy_reg;
        end
    end

    // Square root chain.
    sqrt_state_t             sq_st [SQRT_STEPS+1];
    meta_t                   sq_meta_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0]   sq_vld_reg;

    assign sq_st[0] = '{rad: sum_reg, rem: '0, root: '0};

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        avc_sqrt_cell u_cell (
            .clk    (clk),
            .en     (en),
            .st_in  (sq_st[k]),
            .st_out (sq_st[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_meta_reg[0] <= s2_meta_reg;
            for (int k = 1; k < SQRT_STEPS; k++)
            begin
                sq_meta_reg[k] <= sq_meta_reg[k-1];
            end
        end
    end

    // Scale stage: magnitude times limit, loaded into the divider.
    logic             s3_vld_reg;
    meta_t            s3_meta_reg;
    div_state_t       s3_div_reg;
    logic [PROD_W-1:0] prod_x, prod_y;
    meta_t            sq_last;

    assign sq_last = sq_meta_reg[SQRT_STEPS-1];
    assign prod_x  = sq_last.ax * sq_last.lim;
    assign prod_y  = sq_last.ay * sq_last.lim;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_meta_reg           <= sq_last;
            s3_div_reg.lane_x.rem <= prod_x[PROD_W-1:QUO_W];
            s3_div_reg.lane_x.num <= prod_x[QUO_W-1:0];
            s3_div_reg.lane_x.quo <= '0;
            s3_div_reg.lane_y.rem <= prod_y[PROD_W-1:QUO_W];
            s3_div_reg.lane_y.num <= prod_y[QUO_W-1:0];
            s3_div_reg.lane_y.quo <= '0;
            s3_div_reg.dvs        <= sq_st[SQRT_STEPS].root;
        end
    end

    // Divider chain.
    div_state_t           dv_st [DIV_STEPS+1];
    meta_t                dv_meta_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] dv_vld_reg;

    assign dv_st[0] = s3_div_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        avc_div_cell u_cell (
            .clk    (clk),
            .en     (en),
            .st_in  (dv_st[k]),
            .st_out (dv_st[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_meta_reg[0] <= s3_meta_reg;
            for (int k = 1; k < DIV_STEPS; k++)
            begin
                dv_meta_reg[k] <= dv_meta_reg[k-1];
            end
        end
    end

    // Output stage: pick scaled or original magnitude and restore the sign.
    meta_t dv_last;
    mag_t  mx, my;
    logic  s4_vld_reg;
    vec_t  s4_x_reg, s4_y_reg;
    logic [SIDE_W-1:0] s4_side_reg;

    assign dv_last = dv_meta_reg[DIV_STEPS-1];
    assign mx = dv_last.over ? mag_t'(dv_st[DIV_STEPS].lane_x.quo) : dv_last.ax;
    assign my = dv_last.over ? mag_t'(dv_st[DIV_STEPS].lane_y.quo) : dv_last.ay;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_x_reg    <= apply_sign(dv_last.sx, mx);
            s4_y_reg    <= apply_sign(dv_last.sy, my);
            s4_side_reg <= dv_last.side;
        end
    end

    // Valid bits for every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            sq_vld_reg <= '0;
            s3_vld_reg <= 1'b0;
            dv_vld_reg <= '0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= in_vld;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
            sq_vld_reg <= {sq_vld_reg[SQRT_STEPS-2:0], s2_vld_reg};
            s3_vld_reg <= sq_vld_reg[SQRT_STEPS-1];
            dv_vld_reg <= {dv_vld_reg[DIV_STEPS-2:0], s3_vld_reg};
            s4_vld_reg <= dv_vld_reg[DIV_STEPS-1];
        end
    end

    assign out_vld  = s4_vld_reg;
    assign out_x    = s4_x_reg;
    assign out_y    = s4_y_reg;
    assign out_side = s4_side_reg;
endmodule

// ----- rtl/core/agent_velocity_clamp_step_core.sv -----
`timescale 1ns / 1ps
// Path: acceleration clamp, velocity register, speed clamp, output register.
// Throughput: one agent per cycle unless a waiting result stalls the pipeline;
// each of the two clamp units is a chain of 32 square root cells and 31 divider cells, one bit per cell.
// Reset clears all valid bits and loads the limits: accel 1.0, speed 4.0.
// Depends on avc_pkg, avc_stream_if and avc_clamp.
module agent_velocity_clamp_step_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    avc_stream_if.sink                        agent,
    avc_stream_if.source                      result,
    input  logic                              cfg_we,
    input  logic [avc_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [avc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import avc_pkg::*;

    localparam lim_t ACCEL_RESET = lim_t'(64'd1 << FRAC_BITS);
    localparam lim_t SPEED_RESET = lim_t'(64'd4 << FRAC_BITS);

    typedef struct packed {
        vec_t               pos_x;
        vec_t               pos_y;
        vec_t               vel_x;
        vec_t               vel_y;
        logic [GROUP_W-1:0] grp;
    } side1_t;

    typedef struct packed {
        vec_t pos_x;
        vec_t pos_y;
    } side2_t;

    localparam int SIDE1_W = $bits(side1_t);
    localparam int SIDE2_W = $bits(side2_t);

    // Limit registers, one accel and one speed limit per group.
    lim_t               accel_lim_reg [N_GROUPS];
    lim_t               speed_lim_reg [N_GROUPS];
    logic [GROUP_W-1:0] cfg_grp;

    assign cfg_grp = cfg_index[REG_IDX_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < N_GROUPS; g++)
            begin
                accel_lim_reg[g] <= ACCEL_RESET;
                speed_lim_reg[g] <= SPEED_RESET;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index[0] == CFG_KIND_ACCEL)
            begin
                accel_lim_reg[cfg_grp] <= cfg_data;
            end
            else
            begin
                speed_lim_reg[cfg_grp] <= cfg_data;
            end
        end
    end

    // Pipeline advance: stall only while a result waits and the last
    // stage is occupied.
    logic      en;
    logic      out_load;
    logic      c2_vld;
    logic      result_vld_reg;
    out_item_t result_reg;

    assign out_load    = !result_vld_reg || result.ready;
    assign en          = out_load || !c2_vld;
    assign agent.ready = en;

    // Acceleration clamp.
    side1_t side1_in, c1_side;
    logic   c1_vld;
    vec_t   c1_x, c1_y;

    always_comb
    begin
        side1_in.pos_x = agent.payload.pos_x;
        side1_in.pos_y = agent.payload.pos_y;
        side1_in.vel_x = agent.payload.vel_x;
        side1_in.vel_y = agent.payload.vel_y;
        side1_in.grp   = agent.payload.group_index;
    end

    avc_clamp #(
        .SIDE_W (SIDE1_W)
    ) u_clamp_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (agent.valid),
        .in_x     (agent.payload.acc_x),
        .in_y     (agent.payload.acc_y),
        .in_lim   (accel_lim_reg[agent.payload.group_index]),
        .in_side  (side1_in),
        .out_vld  (c1_vld),
        .out_x    (c1_x),
        .out_y    (c1_y),
        .out_side (c1_side)
    );

    // Velocity update.
    logic               vadd_vld_reg;
    vec_t               vadd_vx_reg, vadd_vy_reg;
    side2_t             vadd_pos_reg;
    logic [GROUP_W-1:0] vadd_grp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vadd_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vadd_vld_reg <= c1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vadd_vx_reg        <= sat_add(c1_side.vel_x, c1_x);
            vadd_vy_reg        <= sat_add(c1_side.vel_y, c1_y);
            vadd_pos_reg.pos_x <= c1_side.pos_x;
            vadd_pos_reg.pos_y <= c1_side.pos_y;
            vadd_grp_reg       <= c1_side.grp;
        end
    end

    // Speed clamp.
    side2_t c2_side;
    vec_t   c2_x, c2_y;

    avc_clamp #(
        .SIDE_W (SIDE2_W)
    ) u_clamp_vel (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vadd_vld_reg),
        .in_x     (vadd_vx_reg),
        .in_y     (vadd_vy_reg),
        .in_lim   (speed_lim_reg[vadd_grp_reg]),
        .in_side  (vadd_pos_reg),
        .out_vld  (c2_vld),
        .out_x    (c2_x),
        .out_y    (c2_y),
        .out_side (c2_side)
    );

    // Position update into the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_vld_reg <= c2_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg.new_pos_x <= sat_add(c2_side.pos_x, c2_x);
            result_reg.new_pos_y <= sat_add(c2_side.pos_y, c2_y);
            result_reg.new_vel_x <= c2_x;
            result_reg.new_vel_y <= c2_y;
        end
    end

    assign result.valid   = result_vld_reg;
    assign result.payload = result_reg;

    // A waiting result with a full last stage must hold off new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_vld_reg && !result.ready && c2_vld |-> !agent.ready)
        else $error("request accepted while pipeline is blocked");

    // A stall freezes the velocity stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vadd_vld_reg) && $stable(vadd_vx_reg) && $stable(vadd_vy_reg))
        else $error("velocity stage moved during a stall");

    // A finished acceleration clamp always lands in the velocity stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        c1_vld && en |=> vadd_vld_reg)
        else $error("item lost between clamp units");

    // A result in the last stage is never dropped when the output loads.
    assert property (@(posedge clk) disable iff (!rst_n)
        c2_vld && out_load |=> result_vld_reg)
        else $error("result lost at output register");
endmodule

// ----- verif/tb_agent_velocity_clamp_step_core.sv -----
`timescale 1ns / 1ps
// Testbench for agent_velocity_clamp_step_core: it streams agent requests,
// predicts each clamped step and compares the results in order.
// Depends on avc_pkg, avc_stream_if and the core itself.
module tb_agent_velocity_clamp_step_core;
    import avc_pkg::*;

    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 137;
    localparam logic [LIM_W-1:0] LIM_MAX = {LIM_W{1'b1}};
    localparam vec_t VEC_MAX = 32'sh7FFF_FFFF;
    localparam vec_t VEC_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    avc_stream_if #(.payload_t(in_item_t))  agent_if ();
    avc_stream_if #(.payload_t(out_item_t)) result_if ();

    agent_velocity_clamp_step_core #(.FRAC_BITS(FRAC)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .agent     (agent_if.sink),
        .result    (result_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the limit registers, accel limit first in each group.
    logic [LIM_W-1:0] limit_regs [N_REGS];
    out_item_t        pending_steps [$];
    int               error_count;
    int               long_hold;

    always #5 clk = ~clk;

    // Floor of the square root, one result bit per pass.
    function automatic logic [63:0] root_floor(logic [63:0] s);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scale a vector down to the limit when its length exceeds it.
    function automatic void clamp_to_limit(inout logic signed [63:0] x,
                                           inout logic signed [63:0] y,
                                           input logic [63:0] lim);
        logic [63:0] mx, my, sq, n, qx, qy;
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        sq = mx * mx + my * my;
        if (sq > lim * lim) begin
            n = root_floor(sq);
            if (n == 0) n = 1;
            qx = (mx * lim) / n;
            qy = (my * lim) / n;
            x  = (x < 0) ? -$signed(qx) : $signed(qx);
            y  = (y < 0) ? -$signed(qy) : $signed(qy);
        end
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic out_item_t predict_step(in_item_t a);
        logic signed [63:0] px, py, vx, vy, ax, ay;
        out_item_t r;
        px = a.pos_x;
        py = a.pos_y;
        vx = a.vel_x;
        vy = a.vel_y;
        ax = a.acc_x;
        ay = a.acc_y;
        clamp_to_limit(ax, ay, {33'd0, limit_regs[2 * a.group_index]});
        vx = clip32(vx + ax);
        vy = clip32(vy + ay);
        clamp_to_limit(vx, vy, {33'd0, limit_regs[2 * a.group_index + 1]});
        px = clip32(px + vx);
        py = clip32(py + vy);
        r.new_pos_x = px[31:0];
        r.new_pos_y = py[31:0];
        r.new_vel_x = vx[31:0];
        r.new_vel_y = vy[31:0];
        return r;
    endfunction

    // Send one agent request after a random gap and record its prediction.
    task automatic send_agent(in_item_t a);
        int unsigned gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            agent_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        agent_if.valid   <= 1'b1;
        agent_if.payload <= a;
        do @(posedge clk); while (!agent_if.ready);
        pending_steps.push_back(predict_step(a));
    endtask

    task automatic wait_drained();
        agent_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_steps.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all eight limits while the core is idle.
    task automatic write_limits(logic [LIM_W-1:0] vals [N_REGS]);
        wait_drained();
        for (int i = 0; i < N_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= i[REG_IDX_W-1:0];
            cfg_data  <= vals[i];
            @(posedge clk);
            limit_regs[i] = vals[i];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic vec_t rand_vec();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            3: return $urandom_range(0, 1) ? VEC_MAX - $urandom_range(0, 255)
                                           : VEC_MIN + $urandom_range(0, 255);
            default: return $signed($urandom_range(0, 32'h0000_FFFF)) - 32'sh0000_8000;
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] rand_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return LIM_MAX;
            2: return LIM_W'($urandom_range(0, 32'h000F_FFFF));
            3: return LIM_W'($urandom_range(0, 32'h00FF_FFFF));
            default: return LIM_W'($urandom) & LIM_MAX;
        endcase
    endfunction

    function automatic in_item_t rand_agent();
        in_item_t a;
        a.pos_x       = rand_vec();
        a.pos_y       = rand_vec();
        a.vel_x       = rand_vec();
        a.vel_y       = rand_vec();
        a.acc_x       = rand_vec();
        a.acc_y       = rand_vec();
        a.group_index = GROUP_W'($urandom_range(0, N_GROUPS - 1));
        return a;
    endfunction

    function automatic in_item_t make_agent(vec_t px, vec_t py, vec_t vx, vec_t vy,
                                            vec_t ax, vec_t ay, int g);
        in_item_t a;
        a.pos_x = px; a.pos_y = py;
        a.vel_x = vx; a.vel_y = vy;
        a.acc_x = ax; a.acc_y = ay;
        a.group_index = g[GROUP_W-1:0];
        return a;
    endfunction

    // Reset limits: in range, over the accel limit, over the speed limit,
    // field extremes and every group.
    task automatic test_reset_limits();
        send_agent(make_agent(0, 0, 0, 0, 0, 0, 0));
        send_agent(make_agent(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000,
                              32'sh0000_4000, 32'sh0000_2000, -32'sh0000_1000, 1));
        send_agent(make_agent(0, 0, 0, 0, 32'sh0005_0000, 32'sh0003_0000, 2));
        send_agent(make_agent(0, 0, 32'sh0010_0000, -32'sh0008_0000, 0, 0, 3));
        send_agent(make_agent(VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, VEC_MAX, 0));
        send_agent(make_agent(VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN, VEC_MIN, 1));
        send_agent(make_agent(VEC_MAX, VEC_MIN, VEC_MIN, VEC_MAX, VEC_MAX, VEC_MIN, 2));
        send_agent(make_agent(-1, 1, -1, 1, -1, 1, 3));
        send_agent(make_agent(32'sh0, 32'sh0, 32'sh0004_0000, 32'sh0, 32'sh0001_0000, 0, 0));
    endtask

    // Zero limits clamp any nonzero vector to the origin.
    task automatic test_zero_limits();
        logic [LIM_W-1:0] vals [N_REGS];
        foreach (vals[i]) vals[i] = '0;
        write_limits(vals);
        for (int g = 0; g < N_GROUPS; g++)
            send_agent(make_agent(32'sh1234_5678, -32'sh0765_4321, VEC_MAX, 1,
                                  -1, VEC_MIN, g));
        send_agent(make_agent(5, 6, 0, 0, 0, 0, 2));
    endtask

    // Widest limits with vectors at the field extremes, where the additions saturate.
    task automatic test_max_limits();
        logic [LIM_W-1:0] vals [N_REGS];
        foreach (vals[i]) vals[i] = LIM_MAX;
        write_limits(vals);
        send_agent(make_agent(VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, 0));
        send_agent(make_agent(VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, VEC_MIN, VEC_MAX, 1));
        send_agent(make_agent(32'sh4000_0000, 0, 32'sh4000_0000, 0, 32'sh4000_0000, 0, 2));
        send_agent(make_agent(0, -32'sh4000_0000, 0, -32'sh4000_0000, 0,
                              -32'sh4000_0000, 3));
        send_agent(make_agent(VEC_MAX, VEC_MAX, 1, 1, 1, 1, 3));
        send_agent(make_agent(VEC_MIN, VEC_MIN, -1, -1, -1, -1, 0));
    endtask

    // Random agents over several random limit settings, with one pause until every
    // result is back and one idle stretch in each phase.
    task automatic test_random_phases();
        logic [LIM_W-1:0] vals [N_REGS];
        for (int ph = 0; ph < 4; ph++) begin
            foreach (vals[i]) vals[i] = rand_limit();
            write_limits(vals);
            for (int n = 0; n < 120; n++) begin
                if (n == 60) wait_drained();
                // Idle stretch: drop valid so the last request is not taken again.
                if (n == 90)
                begin
                    agent_if.valid <= 1'b0;
                    repeat (40) @(posedge clk);
                end
                send_agent(rand_agent());
            end
        end
    endtask

    // The receiver holds off long enough for the pipeline to fill and
    // stall the request side.
    task automatic test_backpressure();
        logic [LIM_W-1:0] vals [N_REGS];
        foreach (vals[i]) vals[i] = rand_limit();
        write_limits(vals);
        long_hold = 3 * PIPE_DEPTH;
        for (int n = 0; n < 150; n++) begin
            agent_if.valid   <= 1'b1;
            agent_if.payload <= rand_agent();
            do @(posedge clk); while (!agent_if.ready);
            pending_steps.push_back(predict_step(agent_if.payload));
        end
    endtask

    // Result side: random stalls, an optional long hold, in-order compare.
    initial begin
        int unsigned stall;
        out_item_t exp_step;
        out_item_t got;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = (long_hold > 0) ? long_hold
                  : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16));
            long_hold = 0;
            if (stall > 0) begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!(result_if.valid && result_if.ready));
            got = result_if.payload;
            if (pending_steps.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else begin
                exp_step = pending_steps.pop_front();
                if (got.new_pos_x !== exp_step.new_pos_x)
                    $display("%0t: new_pos_x expected %h actual %h", $time,
                             exp_step.new_pos_x, got.new_pos_x);
                if (got.new_pos_y !== exp_step.new_pos_y)
                    $display("%0t: new_pos_y expected %h actual %h", $time,
                             exp_step.new_pos_y, got.new_pos_y);
                if (got.new_vel_x !== exp_step.new_vel_x)
                    $display("%0t: new_vel_x expected %h actual %h", $time,
                             exp_step.new_vel_x, got.new_vel_x);
                if (got.new_vel_y !== exp_step.new_vel_y)
                    $display("%0t: new_vel_y expected %h actual %h", $time,
                             exp_step.new_vel_y, got.new_vel_y);
                if (got !== exp_step) error_count++;
            end
        end
    end

    // Watchdog for a hung pipeline.
    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        agent_if.valid   = 1'b0;
        agent_if.payload = '0;
        error_count      = 0;
        long_hold        = 0;
        for (int g = 0; g < N_GROUPS; g++) begin
            limit_regs[2 * g]     = 31'(1 << FRAC);
            limit_regs[2 * g + 1] = 31'(4 << FRAC);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limits();
        test_zero_limits();
        test_max_limits();
        test_random_phases();
        test_backpressure();

        wait_drained();
        repeat (PIPE_DEPTH + 20) @(posedge clk);
        if (error_count == 0 && pending_steps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
